// File: hw/rtl/rflt_pkg.sv
// Shared types and constants for the RTP frame loss tracker.
package rflt_pkg;

    localparam int COUNTER_WIDTH_DEF = 32;
    localparam int LEN_W = 16;
    localparam int STAT_W = 32;

    localparam logic [LEN_W-1:0] RTP_HDR_BYTES = LEN_W'(12);
    localparam logic [LEN_W-1:0] PL_HDR_BYTES = LEN_W'(8);
    localparam logic [LEN_W-1:0] MIN_MEDIA_BYTES = RTP_HDR_BYTES + PL_HDR_BYTES;
    localparam logic [1:0] RTP_VERSION = 2'd2;

    typedef enum logic [3:0] {
        ST_BAD      = 4'd0,
        ST_WAIT     = 4'd1,
        ST_SHORT    = 4'd2,
        ST_DISCARD  = 4'd3,
        ST_LOSS     = 4'd4,
        ST_OOO      = 4'd5,
        ST_ACCEPT   = 4'd6,
        ST_COMPLETE = 4'd7,
        ST_RESYNC   = 4'd8
    } status_t;

    typedef struct packed {
        logic             resync;
        logic [7:0]       header_byte0;
        logic [7:0]       header_byte1;
        logic [15:0]      seq_num;
        logic [31:0]      timestamp;
        logic [LEN_W-1:0] packet_length;
    } hdr_t;

    typedef struct packed {
        status_t           status;
        logic [15:0]       payload_length;
        logic [31:0]       frame_size;
        logic [STAT_W-1:0] rx_packets;
        logic [STAT_W-1:0] lost_packets;
        logic [STAT_W-1:0] out_of_order_count;
        logic [STAT_W-1:0] done_frames;
    } result_t;

endpackage

// File: hw/rtl/rflt_in_stage.sv
// Input register that holds one packet header until the tracker consumes it.
module rflt_in_stage
    import rflt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic        s_tuser,
    input  logic        consume,
    output logic        hdr_valid,
    output hdr_t        hdr
);

    logic valid_reg;
    hdr_t hdr_reg;

    assign s_tready  = !valid_reg || consume;
    assign hdr_valid = valid_reg;
    assign hdr       = hdr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            hdr_reg.resync          <= s_tuser;
            hdr_reg.header_byte0    <= s_tdata[7:0];
            hdr_reg.header_byte1    <= s_tdata[15:8];
            hdr_reg.seq_num         <= s_tdata[31:16];
            hdr_reg.timestamp       <= s_tdata[63:32];
            hdr_reg.packet_length   <= s_tdata[79:64];
        end
    end

endmodule

// File: hw/rtl/rflt_tracker.sv
// Frame and sequence tracking state with its per-packet decision logic.
module rflt_tracker
    import rflt_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    fire,
    input  hdr_t    hdr,
    output result_t res
);

    logic                     waiting_sync_reg, waiting_sync_next;
    logic                     frame_open_reg, frame_open_next;
    logic                     discarding_reg, discarding_next;
    logic [15:0]              expected_seq_reg, expected_seq_next;
    logic [31:0]              current_ts_reg, current_ts_next;
    logic [31:0]              frame_bytes_reg, frame_bytes_next;
    logic [COUNTER_WIDTH-1:0] rx_cnt_reg, rx_cnt_next;
    logic [COUNTER_WIDTH-1:0] lost_cnt_reg, lost_cnt_next;
    logic [COUNTER_WIDTH-1:0] ooo_cnt_reg, ooo_cnt_next;
    logic [COUNTER_WIDTH-1:0] frames_cnt_reg, frames_cnt_next;

    logic        marker;
    logic        bad_hdr;
    logic        new_frame;
    logic        disc_eff;
    logic [31:0] base_bytes;
    logic [15:0] seq_diff;
    logic [15:0] seq_plus1;
    logic [15:0] payload;
    logic [32:0] sum;
    status_t     status;

    assign marker    = hdr.header_byte1[7];
    assign bad_hdr   = (hdr.packet_length < RTP_HDR_BYTES)
                    || (hdr.header_byte0[7:6] != RTP_VERSION);
    assign new_frame = !frame_open_reg || (hdr.timestamp != current_ts_reg);
    assign disc_eff  = new_frame ? 1'b0 : discarding_reg;
    assign base_bytes = new_frame ? 32'd0 : frame_bytes_reg;
    assign seq_diff  = hdr.seq_num - expected_seq_reg;
    assign seq_plus1 = hdr.seq_num + 16'd1;
    assign payload   = 16'(hdr.packet_length - MIN_MEDIA_BYTES);
    assign sum       = {1'b0, base_bytes} + 33'(payload);

    always_comb begin
        waiting_sync_next = waiting_sync_reg;
        frame_open_next   = frame_open_reg;
        discarding_next   = discarding_reg;
        expected_seq_next = expected_seq_reg;
        current_ts_next   = current_ts_reg;
        frame_bytes_next  = frame_bytes_reg;
        rx_cnt_next       = rx_cnt_reg;
        lost_cnt_next     = lost_cnt_reg;
        ooo_cnt_next      = ooo_cnt_reg;
        frames_cnt_next   = frames_cnt_reg;
        status            = ST_BAD;
        res.payload_length = 16'd0;

        if (hdr.resync) begin
            waiting_sync_next = 1'b1;
            frame_open_next   = 1'b0;
            discarding_next   = 1'b0;
            expected_seq_next = 16'd0;
            current_ts_next   = 32'd0;
            frame_bytes_next  = 32'd0;
            rx_cnt_next       = '0;
            lost_cnt_next     = '0;
            ooo_cnt_next      = '0;
            frames_cnt_next   = '0;
            status            = ST_RESYNC;
        end else if (!bad_hdr) begin
            rx_cnt_next = rx_cnt_reg + COUNTER_WIDTH'(1);
            if (waiting_sync_reg) begin
                if (marker) begin
                    waiting_sync_next = 1'b0;
                end
                status = ST_WAIT;
            end else if (hdr.packet_length < MIN_MEDIA_BYTES) begin
                status = ST_SHORT;
            end else begin
                // A new timestamp drops whatever partial frame was open.
                frame_open_next  = 1'b1;
                discarding_next  = disc_eff;
                current_ts_next  = hdr.timestamp;
                frame_bytes_next = base_bytes;
                if (disc_eff) begin
                    expected_seq_next = seq_plus1;
                    status            = ST_DISCARD;
                end else if (seq_diff != 16'd0 && !seq_diff[15]) begin
                    lost_cnt_next     = lost_cnt_reg + COUNTER_WIDTH'(seq_diff);
                    frame_bytes_next  = 32'd0;
                    discarding_next   = 1'b1;
                    expected_seq_next = seq_plus1;
                    status            = ST_LOSS;
                end else if (seq_diff != 16'd0) begin
                    ooo_cnt_next = ooo_cnt_reg + COUNTER_WIDTH'(1);
                    status       = ST_OOO;
                end else begin
                    res.payload_length = payload;
                    frame_bytes_next   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    expected_seq_next  = seq_plus1;
                    if (marker) begin
                        frames_cnt_next = frames_cnt_reg + COUNTER_WIDTH'(1);
                        frame_open_next = 1'b0;
                        status          = ST_COMPLETE;
                    end else begin
                        status = ST_ACCEPT;
                    end
                end
            end
        end

        res.status             = status;
        res.frame_size         = frame_bytes_next;
        res.rx_packets         = STAT_W'(rx_cnt_next);
        res.lost_packets       = STAT_W'(lost_cnt_next);
        res.out_of_order_count = STAT_W'(ooo_cnt_next);
        res.done_frames        = STAT_W'(frames_cnt_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            waiting_sync_reg <= 1'b1;
            frame_open_reg   <= 1'b0;
            discarding_reg   <= 1'b0;
            expected_seq_reg <= 16'd0;
            current_ts_reg   <= 32'd0;
            frame_bytes_reg  <= 32'd0;
            rx_cnt_reg       <= '0;
            lost_cnt_reg     <= '0;
            ooo_cnt_reg      <= '0;
            frames_cnt_reg   <= '0;
        end else if (fire) begin
            waiting_sync_reg <= waiting_sync_next;
            frame_open_reg   <= frame_open_next;
            discarding_reg   <= discarding_next;
            expected_seq_reg <= expected_seq_next;
            current_ts_reg   <= current_ts_next;
            frame_bytes_reg  <= frame_bytes_next;
            rx_cnt_reg       <= rx_cnt_next;
            lost_cnt_reg     <= lost_cnt_next;
            ooo_cnt_reg      <= ooo_cnt_next;
            frames_cnt_reg   <= frames_cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_payload_only_when_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.payload_length != 16'd0 |->
            res.status == ST_ACCEPT || res.status == ST_COMPLETE)
        else $error("payload reported for a packet that was not taken into the frame");

    a_resync_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && hdr.resync |=> waiting_sync_reg && !frame_open_reg
            && frame_bytes_reg == 32'd0 && rx_cnt_reg == '0)
        else $error("resync did not clear tracker state");

    a_complete_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.status == ST_COMPLETE |=> !frame_open_reg && !discarding_reg)
        else $error("frame still open after completion");

    a_loss_discards: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.status == ST_LOSS |=> discarding_reg && frame_bytes_reg == 32'd0)
        else $error("loss did not start discarding");
`endif

endmodule

// File: hw/rtl/rflt_out_stage.sv
// Result register that presents one status word on the master side.
module rflt_out_stage
    import rflt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load,
    input  result_t      res,
    output logic         slot_free,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [175:0] m_tdata,
    output logic [3:0]   m_tuser
);

    logic    valid_reg;
    result_t res_reg;

    assign slot_free = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_tuser   = res_reg.status;
    assign m_tdata   = {res_reg.done_frames, res_reg.out_of_order_count,
                        res_reg.lost_packets, res_reg.rx_packets,
                        res_reg.frame_size, res_reg.payload_length};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

// File: hw/rtl/rtp_frame_loss_tracker.sv
// A header word is held in the input register and its result word in the result register.
// Throughput: one word per cycle while m_tready is high; decision is one compare/add pass.
// The input register refills in the cycle its word moves into the result register.
// Reset (aresetn low, synchronous) empties both registers, clears all statistics and
// frame state, and leaves the tracker waiting for a marker before it syncs.
module rtp_frame_loss_tracker
    import rflt_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // header_byte0, header_byte1, seq_num, timestamp, packet_length
    input  logic [79:0]  s_tdata,
    // command
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // payload_length, frame_size, rx_packets, lost_packets,
    // out_of_order_count, done_frames
    output logic [175:0] m_tdata,
    // status
    output logic [3:0]   m_tuser
);

    logic    hdr_valid;
    hdr_t    hdr;
    logic    slot_free;
    logic    fire;
    result_t res;

    assign fire = hdr_valid && slot_free;

    rflt_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .consume   (fire),
        .hdr_valid (hdr_valid),
        .hdr       (hdr)
    );

    rflt_tracker #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .hdr     (hdr),
        .res     (res)
    );

    rflt_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (fire),
        .res       (res),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
